// File: rtl/lps_pkg.sv
// Shared types, constants and helpers for the launch pad sequencer.
// It depends on nothing else and every other file imports it.
`timescale 1ns / 1ps

package lps_pkg;

  localparam int unsigned KIND_W    = 3;
  localparam int unsigned PAD_W     = 3;
  localparam int unsigned LINK_W    = 2;
  localparam int unsigned ADC_W     = 10;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned CODE_W    = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned PAD_SPAN  = 2 ** PAD_W;

  localparam int unsigned DEF_NUM_PADS     = 8;
  localparam int unsigned DEF_RELAY_TICKS  = 3;
  localparam int unsigned DEF_RESET_TICKS  = 30000;
  localparam int unsigned DEF_DIS_PERIOD   = 100;
  localparam int unsigned DEF_FLASH_PERIOD = 50;

  localparam logic [ADC_W-1:0] DEF_LOW_THR  = ADC_W'(300);
  localparam logic [ADC_W-1:0] DEF_HIGH_THR = ADC_W'(900);

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR = 1'b1;

  localparam logic [LINK_W-1:0] LINK_DISC  = 2'd0;
  localparam logic [LINK_W-1:0] LINK_INIT  = 2'd1;
  localparam logic [LINK_W-1:0] LINK_READY = 2'd2;

  localparam int unsigned OB_EN = 0;
  localparam int unsigned OB_LA = 1;
  localparam int unsigned OB_GR = 2;
  localparam int unsigned OB_RD = 3;

  localparam logic [CODE_W-1:0] CODE_IDLE        = 3'd0;
  localparam logic [CODE_W-1:0] CODE_SW_ENABLE   = 3'd1;
  localparam logic [CODE_W-1:0] CODE_SW_ENABLED  = 3'd2;
  localparam logic [CODE_W-1:0] CODE_PAD_ENABLE  = 3'd3;
  localparam logic [CODE_W-1:0] CODE_PAD_ENABLED = 3'd4;
  localparam logic [CODE_W-1:0] CODE_LAUNCH      = 3'd5;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK       = 3'd0,
    KIND_SW_ENABLE  = 3'd1,
    KIND_SW_RESET   = 3'd2,
    KIND_PAD_ENABLE = 3'd3,
    KIND_PAD_RESET  = 3'd4,
    KIND_LAUNCH     = 3'd5,
    KIND_UNLAUNCH   = 3'd6
  } kind_t;

  typedef enum logic [5:0] {
    ST_IDLE        = 6'b000001,
    ST_SW_ENABLE   = 6'b000010,
    ST_SW_ENABLED  = 6'b000100,
    ST_PAD_ENABLE  = 6'b001000,
    ST_PAD_ENABLED = 6'b010000,
    ST_LAUNCH      = 6'b100000
  } seq_state_t;

  typedef struct packed {
    seq_state_t       st;
    logic [CNT_W-1:0] timeout;
    logic [CNT_W-1:0] flash;
    logic [CNT_W-1:0] relay;
    logic [3:0]       outs;
  } pad_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LINK_W-1:0] link;
    logic [ADC_W-1:0]  ref_a;
    logic [ADC_W-1:0]  ref_b;
    logic [ADC_W-1:0]  cont_volt;
  } event_t;

  localparam pad_t PAD_CLEAR = '{
    st:      ST_IDLE,
    timeout: '0,
    flash:   '0,
    relay:   '0,
    outs:    '0
  };

  function automatic logic [CODE_W-1:0] state_code(seq_state_t st);
    logic [CODE_W-1:0] code;
    case (st)
      ST_IDLE:        code = CODE_IDLE;
      ST_SW_ENABLE:   code = CODE_SW_ENABLE;
      ST_SW_ENABLED:  code = CODE_SW_ENABLED;
      ST_PAD_ENABLE:  code = CODE_PAD_ENABLE;
      ST_PAD_ENABLED: code = CODE_PAD_ENABLED;
      ST_LAUNCH:      code = CODE_LAUNCH;
      default:        code = CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/lps_pad_logic.sv
// Next-state logic for one pad: applies a registered event to that pad's state.
// Depends on lps_pkg for the pad and event types and the state and kind codes.
`timescale 1ns / 1ps

module lps_pad_logic #(
  parameter int unsigned RELAY_TICKS  = lps_pkg::DEF_RELAY_TICKS,
  parameter int unsigned RESET_TICKS  = lps_pkg::DEF_RESET_TICKS,
  parameter int unsigned DIS_PERIOD   = lps_pkg::DEF_DIS_PERIOD,
  parameter int unsigned FLASH_PERIOD = lps_pkg::DEF_FLASH_PERIOD
) (
  input  lps_pkg::event_t                ev_i,
  input  lps_pkg::pad_t                  pad_i,
  input  logic                           siren_i,
  input  logic [lps_pkg::ADC_W-1:0]      low_thr_i,
  input  logic [lps_pkg::ADC_W-1:0]      high_thr_i,
  output lps_pkg::pad_t                  pad_nxt,
  output logic                           siren_nxt
);
  import lps_pkg::*;

  localparam logic [CNT_W-1:0] RelayLoad = CNT_W'(RELAY_TICKS);
  localparam logic [CNT_W-1:0] ResetLoad = CNT_W'(RESET_TICKS);
  localparam logic [CNT_W-1:0] DisHalf   = CNT_W'(DIS_PERIOD / 2);
  localparam logic [CNT_W-1:0] FlashHalf = CNT_W'(FLASH_PERIOD / 2);
  localparam logic [CNT_W:0]   DisFull   = (CNT_W + 1)'(DIS_PERIOD);
  localparam logic [CNT_W:0]   FlashFull = (CNT_W + 1)'(FLASH_PERIOD);

  logic [CNT_W-1:0] tmo_dec;
  logic [CNT_W-1:0] relay_dec;
  logic [CNT_W:0]   flash_inc;
  logic [CNT_W-1:0] dis_wrap;
  logic [CNT_W-1:0] fl_wrap;
  logic             dis_on;
  logic             fl_on;
  logic             relay_done;
  logic             good;

  assign tmo_dec    = pad_i.timeout - CNT_W'(1);
  assign relay_dec  = pad_i.relay - CNT_W'(1);
  assign relay_done = (pad_i.relay <= CNT_W'(1));
  assign flash_inc  = {1'b0, pad_i.flash} + (CNT_W + 1)'(1);
  assign dis_on     = (pad_i.flash < DisHalf);
  assign fl_on      = (pad_i.flash < FlashHalf);
  assign dis_wrap   = (flash_inc >= DisFull) ? CNT_W'(flash_inc - DisFull)
                                             : flash_inc[CNT_W-1:0];
  assign fl_wrap    = (flash_inc >= FlashFull) ? CNT_W'(flash_inc - FlashFull)
                                               : flash_inc[CNT_W-1:0];
  assign good = ((ev_i.ref_a > ev_i.ref_b) && (ev_i.cont_volt < low_thr_i)) ||
                ((ev_i.ref_a < ev_i.ref_b) && (ev_i.cont_volt > high_thr_i));

  always_comb begin
    pad_nxt   = pad_i;
    siren_nxt = siren_i;
    case (kind_t'(ev_i.kind))
      KIND_TICK: begin
        if ((pad_i.timeout != '0) && (tmo_dec == '0)) begin
          pad_nxt   = PAD_CLEAR;
          siren_nxt = 1'b0;
        end else begin
          if (pad_i.timeout != '0) begin
            pad_nxt.timeout = tmo_dec;
          end
          case (pad_i.st)
            ST_IDLE: begin
              if (ev_i.link == LINK_DISC) begin
                pad_nxt.flash       = dis_wrap;
                pad_nxt.outs[OB_GR] = dis_on;
                pad_nxt.outs[OB_RD] = dis_on;
              end else if (ev_i.link == LINK_INIT) begin
                pad_nxt.flash       = dis_wrap;
                pad_nxt.outs[OB_RD] = dis_on;
              end else if (ev_i.link == LINK_READY) begin
                pad_nxt.outs[OB_GR] = 1'b0;
                pad_nxt.outs[OB_RD] = 1'b0;
              end
            end
            ST_SW_ENABLE: begin
              pad_nxt.relay = relay_done ? '0 : relay_dec;
              if (relay_done) begin
                pad_nxt.st = ST_SW_ENABLED;
              end
            end
            ST_PAD_ENABLE: begin
              pad_nxt.relay = relay_done ? '0 : relay_dec;
              if (relay_done) begin
                pad_nxt.st = ST_PAD_ENABLED;
              end
            end
            ST_SW_ENABLED, ST_PAD_ENABLED: begin
              pad_nxt.outs[OB_GR] = good;
              pad_nxt.outs[OB_RD] = !good;
            end
            ST_LAUNCH: begin
              pad_nxt.flash       = fl_wrap;
              pad_nxt.outs[OB_GR] = 1'b0;
              pad_nxt.outs[OB_RD] = fl_on;
            end
            default: begin
              pad_nxt = pad_i;
            end
          endcase
        end
      end
      KIND_SW_ENABLE: begin
        if (pad_i.st == ST_IDLE) begin
          pad_nxt.outs[OB_EN] = 1'b1;
          pad_nxt.relay       = RelayLoad;
          pad_nxt.st          = ST_SW_ENABLE;
        end
      end
      KIND_SW_RESET: begin
        if ((pad_i.st == ST_SW_ENABLE) || (pad_i.st == ST_SW_ENABLED)) begin
          pad_nxt.st   = ST_IDLE;
          pad_nxt.outs = '0;
        end
      end
      KIND_PAD_ENABLE: begin
        pad_nxt.outs[OB_LA] = 1'b0;
        pad_nxt.outs[OB_EN] = 1'b1;
        pad_nxt.relay       = RelayLoad;
        pad_nxt.timeout     = ResetLoad;
        pad_nxt.st          = ST_PAD_ENABLE;
        siren_nxt           = 1'b1;
      end
      KIND_PAD_RESET: begin
        pad_nxt   = PAD_CLEAR;
        siren_nxt = 1'b0;
      end
      KIND_LAUNCH: begin
        if (pad_i.st == ST_PAD_ENABLED) begin
          pad_nxt.timeout     = ResetLoad;
          pad_nxt.outs[OB_LA] = 1'b1;
          pad_nxt.flash       = '0;
          pad_nxt.st          = ST_LAUNCH;
        end
      end
      KIND_UNLAUNCH: begin
        pad_nxt.outs[OB_LA] = 1'b0;
        pad_nxt.timeout     = ResetLoad;
        pad_nxt.flash       = '0;
        pad_nxt.st          = ST_PAD_ENABLED;
      end
      default: begin
        pad_nxt = pad_i;
      end
    endcase
  end

endmodule

// File: rtl/launch_pad_sequencer.sv
// Top level of the launch pad sequencer: event register, per-pad state file,
// result register and threshold registers. Depends on lps_pkg and lps_pad_logic.
//
//   Channel  Handshake               Carries
//   in       start, busy             kind, pad index, link, references, continuity
//   out      out_valid (strobe)      pad, state, relays, LEDs, siren
//   cfg      cfg_valid, cfg_ready    register index and data
//
// One event is taken every cycle; busy never rises.
// A result appears once its event is taken and has passed through the event register,
// then through the pad update into the result register.
// Reset is synchronous and clears every pad to idle and the thresholds to 300 and 900.
// The receiver cannot stall; each result is shown for one cycle only.
`timescale 1ns / 1ps

module launch_pad_sequencer #(
  parameter int unsigned NUM_PADS     = lps_pkg::DEF_NUM_PADS,
  parameter int unsigned RELAY_TICKS  = lps_pkg::DEF_RELAY_TICKS,
  parameter int unsigned RESET_TICKS  = lps_pkg::DEF_RESET_TICKS,
  parameter int unsigned DIS_PERIOD   = lps_pkg::DEF_DIS_PERIOD,
  parameter int unsigned FLASH_PERIOD = lps_pkg::DEF_FLASH_PERIOD
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [lps_pkg::KIND_W-1:0]       in_kind,
  input  logic [lps_pkg::PAD_W-1:0]        in_pad_index,
  input  logic [lps_pkg::LINK_W-1:0]       in_link_state,
  input  logic [lps_pkg::ADC_W-1:0]        in_ref_a,
  input  logic [lps_pkg::ADC_W-1:0]        in_ref_b,
  input  logic [lps_pkg::ADC_W-1:0]        in_cont_volt,
  output logic                             out_valid,
  output logic [lps_pkg::PAD_W-1:0]        out_pad_out,
  output logic [lps_pkg::CODE_W-1:0]       out_pad_state,
  output logic                             out_enable_relay,
  output logic                             out_launch_relay,
  output logic                             out_green_led,
  output logic                             out_red_led,
  output logic                             out_siren_on,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lps_pkg::ADC_W-1:0]        cfg_data
);
  import lps_pkg::*;

  logic               in_valid_r;
  event_t             ev_r;
  logic [PAD_W-1:0]   pad_idx_r;
  pad_t               pads_r [NUM_PADS];
  logic               siren_r;
  logic [ADC_W-1:0]   low_thr_r;
  logic [ADC_W-1:0]   high_thr_r;
  logic [NUM_PADS-1:0] hit;
  logic               in_range;
  pad_t               cur_pad;
  pad_t               pad_nxt;
  logic               siren_nxt;

  logic               out_valid_r;
  logic [PAD_W-1:0]   out_pad_r;
  logic [CODE_W-1:0]  out_state_r;
  logic [3:0]         out_bits_r;
  logic               out_siren_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_thr_r  <= DEF_LOW_THR;
      high_thr_r <= DEF_HIGH_THR;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LOW_THR:  low_thr_r  <= cfg_data;
        CFG_HIGH_THR: high_thr_r <= cfg_data;
        default:      low_thr_r  <= low_thr_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      ev_r.kind      <= in_kind;
      ev_r.link      <= in_link_state;
      ev_r.ref_a     <= in_ref_a;
      ev_r.ref_b     <= in_ref_b;
      ev_r.cont_volt <= in_cont_volt;
      pad_idx_r      <= in_pad_index;
    end
  end

  for (genvar p = 0; p < NUM_PADS; p++) begin : g_hit
    assign hit[p] = (p < PAD_SPAN) && (pad_idx_r == PAD_W'(p));
  end

  assign in_range = |hit;

  always_comb begin
    cur_pad = PAD_CLEAR;
    for (int p = 0; p < NUM_PADS; p++) begin
      if (hit[p]) begin
        cur_pad = pads_r[p];
      end
    end
  end

  lps_pad_logic #(
    .RELAY_TICKS (RELAY_TICKS),
    .RESET_TICKS (RESET_TICKS),
    .DIS_PERIOD  (DIS_PERIOD),
    .FLASH_PERIOD(FLASH_PERIOD)
  ) u_pad_logic (
    .ev_i      (ev_r),
    .pad_i     (cur_pad),
    .siren_i   (siren_r),
    .low_thr_i (low_thr_r),
    .high_thr_i(high_thr_r),
    .pad_nxt   (pad_nxt),
    .siren_nxt (siren_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_PADS; p++) begin
        pads_r[p] <= PAD_CLEAR;
      end
      siren_r <= 1'b0;
    end else if (in_valid_r) begin
      for (int p = 0; p < NUM_PADS; p++) begin
        if (hit[p]) begin
          pads_r[p] <= pad_nxt;
        end
      end
      if (in_range) begin
        siren_r <= siren_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      out_pad_r   <= pad_idx_r;
      out_state_r <= in_range ? state_code(pad_nxt.st) : CODE_IDLE;
      out_bits_r  <= in_range ? pad_nxt.outs : 4'b0000;
      out_siren_r <= in_range ? siren_nxt : siren_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pad_out      = out_pad_r;
  assign out_pad_state    = out_state_r;
  assign out_enable_relay = out_bits_r[OB_EN];
  assign out_launch_relay = out_bits_r[OB_LA];
  assign out_green_led    = out_bits_r[OB_GR];
  assign out_red_led      = out_bits_r[OB_RD];
  assign out_siren_on     = out_siren_r;

endmodule

// File: rtl/lps_checker.sv
// Port-level checks for the launch pad sequencer, bound to the top level.
// Depends on lps_pkg for field widths and state codes.
`timescale 1ns / 1ps

module lps_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic [lps_pkg::PAD_W-1:0]        in_pad_index,
  input logic                             out_valid,
  input logic [lps_pkg::PAD_W-1:0]        out_pad_out,
  input logic [lps_pkg::CODE_W-1:0]       out_pad_state,
  input logic                             out_enable_relay,
  input logic                             out_launch_relay
);
  import lps_pkg::*;

  a_beat_gives_result: assert property (
    @(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid
  ) else $error("accepted beat produced no result two cycles later");

  a_result_has_beat: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start && !busy, 2) && (out_pad_out == $past(in_pad_index, 2)))
  ) else $error("result without a matching accepted beat");

  a_launch_relay_state: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_launch_relay == (out_pad_state == CODE_LAUNCH))
  ) else $error("launch relay disagrees with launch state");

  a_idle_relays_off: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && (out_pad_state == CODE_IDLE)) |-> (!out_enable_relay && !out_launch_relay)
  ) else $error("relay driven while pad is idle");

  a_state_code_range: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pad_state <= CODE_LAUNCH)
  ) else $error("state code out of range");

endmodule

bind launch_pad_sequencer lps_checker u_lps_checker (.*);

// File: tb/tb.sv
// Self-checking testbench for launch_pad_sequencer: random and directed pad events,
// a clocked driver and monitor, and a per-pad prediction of every result beat.
// Depends on lps_pkg and the launch_pad_sequencer RTL only.
`timescale 1ns / 1ps

module tb;
  import lps_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 900000;
  localparam int unsigned MAX_GAP     = 12;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [PAD_W-1:0]  pad;
    logic [LINK_W-1:0] link;
    logic [ADC_W-1:0]  ref_a;
    logic [ADC_W-1:0]  ref_b;
    logic [ADC_W-1:0]  cont_volt;
    int unsigned       gap;
  } pad_event_t;

  typedef struct packed {
    logic [PAD_W-1:0]  pad;
    logic [CODE_W-1:0] state;
    logic              enable;
    logic              launch;
    logic              green;
    logic              red;
    logic              siren;
  } pad_status_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [KIND_W-1:0]    in_kind = '0;
  logic [PAD_W-1:0]     in_pad_index = '0;
  logic [LINK_W-1:0]    in_link_state = '0;
  logic [ADC_W-1:0]     in_ref_a = '0;
  logic [ADC_W-1:0]     in_ref_b = '0;
  logic [ADC_W-1:0]     in_cont_volt = '0;
  logic                 out_valid;
  logic [PAD_W-1:0]     out_pad_out;
  logic [CODE_W-1:0]    out_pad_state;
  logic                 out_enable_relay;
  logic                 out_launch_relay;
  logic                 out_green_led;
  logic                 out_red_led;
  logic                 out_siren_on;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADC_W-1:0]     cfg_data = '0;

  launch_pad_sequencer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_pad_index     (in_pad_index),
    .in_link_state    (in_link_state),
    .in_ref_a         (in_ref_a),
    .in_ref_b         (in_ref_b),
    .in_cont_volt     (in_cont_volt),
    .out_valid        (out_valid),
    .out_pad_out      (out_pad_out),
    .out_pad_state    (out_pad_state),
    .out_enable_relay (out_enable_relay),
    .out_launch_relay (out_launch_relay),
    .out_green_led    (out_green_led),
    .out_red_led      (out_red_led),
    .out_siren_on     (out_siren_on),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  pad_event_t  event_backlog[$];
  pad_status_t status_due[$];
  pad_event_t  active_event;
  bit          event_on_bus = 1'b0;
  bit          event_taken = 1'b0;
  bit          burst = 1'b0;
  int unsigned gap_waited = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;

  logic [CODE_W-1:0] pad_code [PAD_SPAN];
  logic [CNT_W-1:0]  pad_timeout [PAD_SPAN];
  logic [CNT_W-1:0]  pad_flash [PAD_SPAN];
  logic [CNT_W-1:0]  pad_relay [PAD_SPAN];
  logic [3:0]        pad_outs [PAD_SPAN];
  logic              siren;
  logic [ADC_W-1:0]  thr_low;
  logic [ADC_W-1:0]  thr_high;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void clear_pad(int unsigned p);
    pad_code[p]    = CODE_IDLE;
    pad_outs[p]    = '0;
    pad_timeout[p] = '0;
    pad_flash[p]   = '0;
    pad_relay[p]   = '0;
    siren          = 1'b0;
  endfunction

  function automatic logic flash_next(int unsigned p, int unsigned period);
    logic on;
    on = (32'(pad_flash[p]) < period / 2);
    pad_flash[p] = CNT_W'((32'(pad_flash[p]) + 1) % period);
    return on;
  endfunction

  function automatic logic relay_done(int unsigned p);
    if (pad_relay[p] <= 1) begin
      pad_relay[p] = '0;
      return 1'b1;
    end
    pad_relay[p] = pad_relay[p] - 1'b1;
    return 1'b0;
  endfunction

  function automatic pad_status_t sequence_pad(pad_event_t ev);
    pad_status_t r;
    int unsigned p;
    logic on;
    logic good;
    logic expired;
    r = '0;
    p = ev.pad;
    r.pad = ev.pad;
    if (p < DEF_NUM_PADS) begin
      case (ev.kind)
        KIND_TICK: begin
          expired = 1'b0;
          if (pad_timeout[p] != 0) begin
            pad_timeout[p] = pad_timeout[p] - 1'b1;
            if (pad_timeout[p] == 0) begin
              clear_pad(p);
              expired = 1'b1;
            end
          end
          if (!expired) begin
            case (pad_code[p])
              CODE_IDLE: begin
                if (ev.link == LINK_DISC) begin
                  on = flash_next(p, DEF_DIS_PERIOD);
                  pad_outs[p][OB_GR] = on;
                  pad_outs[p][OB_RD] = on;
                end else if (ev.link == LINK_INIT) begin
                  on = flash_next(p, DEF_DIS_PERIOD);
                  pad_outs[p][OB_RD] = on;
                end else if (ev.link == LINK_READY) begin
                  pad_outs[p][OB_GR] = 1'b0;
                  pad_outs[p][OB_RD] = 1'b0;
                end
              end
              CODE_SW_ENABLE: begin
                if (relay_done(p)) pad_code[p] = CODE_SW_ENABLED;
              end
              CODE_SW_ENABLED, CODE_PAD_ENABLED: begin
                good = (ev.ref_a > ev.ref_b && ev.cont_volt < thr_low) ||
                       (ev.ref_a < ev.ref_b && ev.cont_volt > thr_high);
                pad_outs[p][OB_GR] = good;
                pad_outs[p][OB_RD] = !good;
              end
              CODE_PAD_ENABLE: begin
                if (relay_done(p)) pad_code[p] = CODE_PAD_ENABLED;
              end
              CODE_LAUNCH: begin
                pad_outs[p][OB_GR] = 1'b0;
                on = flash_next(p, DEF_FLASH_PERIOD);
                pad_outs[p][OB_RD] = on;
              end
              default: ;
            endcase
          end
        end
        KIND_SW_ENABLE: begin
          if (pad_code[p] == CODE_IDLE) begin
            pad_outs[p][OB_EN] = 1'b1;
            pad_relay[p] = CNT_W'(DEF_RELAY_TICKS);
            pad_code[p] = CODE_SW_ENABLE;
          end
        end
        KIND_SW_RESET: begin
          if (pad_code[p] == CODE_SW_ENABLE || pad_code[p] == CODE_SW_ENABLED) begin
            pad_code[p] = CODE_IDLE;
            pad_outs[p] = '0;
          end
        end
        KIND_PAD_ENABLE: begin
          pad_outs[p][OB_LA] = 1'b0;
          pad_outs[p][OB_EN] = 1'b1;
          siren = 1'b1;
          pad_relay[p] = CNT_W'(DEF_RELAY_TICKS);
          pad_timeout[p] = CNT_W'(DEF_RESET_TICKS);
          pad_code[p] = CODE_PAD_ENABLE;
        end
        KIND_PAD_RESET: clear_pad(p);
        KIND_LAUNCH: begin
          if (pad_code[p] == CODE_PAD_ENABLED) begin
            pad_timeout[p] = CNT_W'(DEF_RESET_TICKS);
            pad_outs[p][OB_LA] = 1'b1;
            pad_flash[p] = '0;
            pad_code[p] = CODE_LAUNCH;
          end
        end
        KIND_UNLAUNCH: begin
          pad_outs[p][OB_LA] = 1'b0;
          pad_timeout[p] = CNT_W'(DEF_RESET_TICKS);
          pad_flash[p] = '0;
          pad_code[p] = CODE_PAD_ENABLED;
        end
        default: ;
      endcase
      r.state  = pad_code[p];
      r.enable = pad_outs[p][OB_EN];
      r.launch = pad_outs[p][OB_LA];
      r.green  = pad_outs[p][OB_GR];
      r.red    = pad_outs[p][OB_RD];
    end
    r.siren = siren;
    return r;
  endfunction

  function automatic void check_field(string name, logic [2:0] want, logic [2:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function automatic logic [ADC_W-1:0] adc_pick();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return ADC_W'($urandom_range(0, 2 ** ADC_W - 1));
    endcase
  endfunction

  task automatic queue_event(input logic [KIND_W-1:0] kind, input logic [PAD_W-1:0] pad,
                             input logic [LINK_W-1:0] link, input logic [ADC_W-1:0] a,
                             input logic [ADC_W-1:0] b, input logic [ADC_W-1:0] cv);
    pad_event_t ev;
    ev.kind      = kind;
    ev.pad       = pad;
    ev.link      = link;
    ev.ref_a     = a;
    ev.ref_b     = b;
    ev.cont_volt = cv;
    ev.gap       = burst ? 0 : $urandom_range(0, MAX_GAP);
    event_backlog.push_back(ev);
  endtask

  task automatic queue_command(input logic [KIND_W-1:0] kind, input logic [PAD_W-1:0] pad);
    queue_event(kind, pad, LINK_W'($urandom_range(0, 3)), adc_pick(), adc_pick(), adc_pick());
  endtask

  task automatic queue_tick(input logic [PAD_W-1:0] pad);
    logic [ADC_W-1:0] a;
    logic [ADC_W-1:0] b;
    a = adc_pick();
    b = ($urandom_range(0, 7) == 0) ? a : adc_pick();
    queue_event(KIND_TICK, pad, LINK_W'($urandom_range(0, 3)), a, b, adc_pick());
  endtask

  task automatic queue_traffic(input int unsigned n);
    int unsigned base;
    logic [PAD_W-1:0] p;
    base = event_backlog.size();
    while (event_backlog.size() < base + n) begin
      burst = ($urandom_range(0, 3) == 0);
      p = PAD_W'($urandom_range(0, PAD_SPAN - 1));
      case ($urandom_range(0, 9))
        0, 1: begin
          queue_command(KIND_SW_ENABLE, p);
          repeat ($urandom_range(0, 6)) queue_tick(p);
          if ($urandom_range(0, 2) != 0) queue_command(KIND_SW_RESET, p);
        end
        2, 3, 4: begin
          queue_command(KIND_PAD_ENABLE, p);
          repeat ($urandom_range(0, 5)) queue_tick(p);
          queue_command(KIND_LAUNCH, p);
          repeat ($urandom_range(0, 8)) queue_tick(p);
          if ($urandom_range(0, 1) != 0) begin
            queue_command(KIND_UNLAUNCH, p);
            repeat ($urandom_range(0, 3)) queue_tick(p);
            queue_command(KIND_LAUNCH, p);
            repeat ($urandom_range(0, 4)) queue_tick(p);
          end
          case ($urandom_range(0, 2))
            0: queue_command(KIND_PAD_RESET, p);
            1: queue_command(KIND_UNLAUNCH, p);
            default: ;
          endcase
        end
        5: repeat ($urandom_range(1, 30)) queue_tick(p);
        default: queue_command(KIND_W'($urandom_range(0, 7)), p);
      endcase
    end
  endtask

  task automatic wait_drained();
    while (event_backlog.size() != 0 || event_on_bus || status_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_thresholds(input logic [ADC_W-1:0] lo, input logic [ADC_W-1:0] hi);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_LOW_THR;
    cfg_data  <= lo;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_index <= CFG_HIGH_THR;
    cfg_data  <= hi;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Monitor: checks result beats, tracks register writes and predicts each taken event.
  always @(posedge clk) begin
    pad_status_t want;
    event_taken = 1'b0;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (status_due.size() == 0) begin
          $error("result beat for pad %0d with no event waiting for it", out_pad_out);
          errors++;
        end else begin
          want = status_due.pop_front();
          check_field("pad_out", want.pad, out_pad_out);
          check_field("pad_state", want.state, out_pad_state);
          check_field("enable_relay", want.enable, out_enable_relay);
          check_field("launch_relay", want.launch, out_launch_relay);
          check_field("green_led", want.green, out_green_led);
          check_field("red_led", want.red, out_red_led);
          check_field("siren_on", want.siren, out_siren_on);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_LOW_THR) thr_low = cfg_data;
        else if (cfg_index == CFG_HIGH_THR) thr_high = cfg_data;
      end
      if (start && !busy) begin
        event_taken = 1'b1;
        status_due.push_back(sequence_pad(active_event));
      end
    end
  end

  // Driver: presents one event per beat after its idle gap and holds it until taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (event_on_bus && event_taken) event_on_bus = 1'b0;
      if (!event_on_bus && event_backlog.size() != 0) begin
        if (gap_waited < event_backlog[0].gap) begin
          gap_waited++;
        end else begin
          active_event = event_backlog.pop_front();
          gap_waited = 0;
          event_on_bus = 1'b1;
        end
      end
      start <= event_on_bus;
      if (event_on_bus) begin
        in_kind       <= active_event.kind;
        in_pad_index  <= active_event.pad;
        in_link_state <= active_event.link;
        in_ref_a      <= active_event.ref_a;
        in_ref_b      <= active_event.ref_b;
        in_cont_volt  <= active_event.cont_volt;
      end else begin
        in_kind       <= KIND_W'($urandom_range(0, 7));
        in_pad_index  <= PAD_W'($urandom_range(0, PAD_SPAN - 1));
        in_link_state <= LINK_W'($urandom_range(0, 3));
        in_ref_a      <= adc_pick();
        in_ref_b      <= adc_pick();
        in_cont_volt  <= adc_pick();
      end
    end
  end

  initial begin
    for (int unsigned i = 0; i < PAD_SPAN; i++) clear_pad(i);
    thr_low  = DEF_LOW_THR;
    thr_high = DEF_HIGH_THR;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    burst = 1'b0;
    queue_event(KIND_TICK, 3'd0, LINK_DISC, '0, '0, '0);
    queue_event(KIND_TICK, 3'd0, LINK_INIT, '1, '1, '1);
    queue_event(KIND_TICK, 3'd0, LINK_READY, '1, '0, '1);
    queue_event(KIND_TICK, 3'd0, 2'd3, '0, '1, '0);
    queue_event(3'd7, 3'd1, 2'd3, '1, '1, '1);
    queue_event(KIND_LAUNCH, 3'd2, LINK_READY, '0, '0, '0);
    queue_event(KIND_SW_RESET, 3'd2, LINK_READY, '0, '0, '0);
    queue_event(KIND_SW_ENABLE, 3'd2, LINK_READY, '0, '0, '0);
    queue_event(KIND_SW_ENABLE, 3'd2, LINK_READY, '0, '0, '0);
    repeat (3) queue_event(KIND_TICK, 3'd2, LINK_READY, '1, '0, '0);
    queue_event(KIND_TICK, 3'd2, LINK_READY, '0, '1, '1);
    queue_event(KIND_TICK, 3'd2, LINK_READY, 10'd512, 10'd512, '0);
    queue_event(KIND_SW_RESET, 3'd2, LINK_READY, '0, '0, '0);
    queue_event(KIND_PAD_ENABLE, 3'd7, LINK_READY, '0, '0, '0);
    repeat (3) queue_event(KIND_TICK, 3'd7, LINK_READY, '1, '0, '1);
    queue_event(KIND_LAUNCH, 3'd7, LINK_READY, '0, '0, '0);
    repeat (2) queue_event(KIND_TICK, 3'd7, LINK_DISC, '0, '0, '0);
    queue_event(KIND_UNLAUNCH, 3'd7, LINK_READY, '0, '0, '0);
    queue_event(KIND_SW_RESET, 3'd7, LINK_READY, '0, '0, '0);
    queue_event(KIND_PAD_RESET, 3'd7, LINK_READY, '0, '0, '0);
    queue_event(KIND_UNLAUNCH, 3'd6, LINK_READY, '0, '0, '0);
    wait_drained();

    set_thresholds('0, '1);
    repeat (4) begin
      queue_traffic(80);
      wait_drained();
    end

    set_thresholds('1, '0);
    repeat (4) begin
      queue_traffic(80);
      wait_drained();
    end

    set_thresholds(adc_pick(), adc_pick());
    repeat (4) begin
      queue_traffic(80);
      wait_drained();
    end

    set_thresholds(ADC_W'($urandom_range(0, 1023)), ADC_W'($urandom_range(0, 1023)));
    repeat (2) begin
      queue_traffic(80);
      wait_drained();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
